FILE: rtl/lms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear move segmenter package
// Shared widths, codes, queue and result types, and the dead-band helper.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int POS_W        = 24;
    localparam int DELTA_W      = POS_W + 1;
    localparam int FEED_W       = 16;
    localparam int SPM_W        = 7;
    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int QUO_W        = $clog2(MAX_SEGMENTS);
    localparam int DEAD_BAND    = 100;
    localparam int UM_PER_MM    = 1000;
    localparam int SAT_LIMIT    = MAX_SEGMENTS * UM_PER_MM;
    localparam int NREM_W       = $clog2(SAT_LIMIT);
    localparam int SUM_W        = POS_W + 1;
    localparam int PROD_W       = SUM_W + SPM_W;
    localparam int DIV_CNT_W    = $clog2(POS_W);

    // Floor division by a millimetre as a multiply by the rounded-up reciprocal.
    // It is exact for every product below the saturation limit.
    localparam int RECIP_SHIFT  = 26;
    localparam int RECIP_W      = 17;
    localparam int RECIP_MUL    = (2**RECIP_SHIFT + UM_PER_MM - 1) / UM_PER_MM;

    // Reset values of the configuration registers
    localparam logic [SPM_W-1:0]  SPM_RESET   = SPM_W'(10);
    localparam logic [FEED_W-1:0] SPEED_RESET = FEED_W'(1000);

    // Request codes
    typedef enum logic [2:0] {
        REQ_MOVE   = 3'd0,
        REQ_ABS    = 3'd1,
        REQ_REL    = 3'd2,
        REQ_HOME   = 3'd3,
        REQ_SETPOS = 3'd4
    } req_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_SPM = 2'd0,
        CFG_SSX = 2'd1,
        CFG_SSY = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [SPM_W-1:0]  spm;
        logic [FEED_W-1:0] ssx;
        logic [FEED_W-1:0] ssy;
    } cfg_t;

    // One classified command on its way from the front to the back
    typedef struct packed {
        logic                      is_xy;
        logic                      is_rel;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [POS_W-1:0]   z;
        logic signed [POS_W-1:0]   e;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [DELTA_W-1:0] de;
        logic [FEED_W-1:0]         spd_x;
        logic [FEED_W-1:0]         spd_y;
        logic [FEED_W-1:0]         spd_z;
    } cmd_t;

    // One result segment
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] e;
        logic [FEED_W-1:0]       spd_x;
        logic [FEED_W-1:0]       spd_y;
        logic [FEED_W-1:0]       spd_z;
        logic                    is_rel;
        logic                    last;
    } seg_t;

    // Deltas whose magnitude lies under the dead band are dropped.
    function automatic logic signed [DELTA_W-1:0] dead_band(
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [DELTA_W-1:0] lim;
        lim = DELTA_W'(DEAD_BAND);
        return ((d > -lim) && (d < lim)) ? '0 : d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear move segmenter front end
// Accepts commands, keeps position, extruder, feedrate and mode, and pushes
// classified moves into the command queue.
// ----------------------------------------------------------------------------
module lms_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire lms_pkg::cfg_t                     cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [2:0]                        req_type,
    input  wire logic                              x_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  x_target,
    input  wire logic                              y_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  y_target,
    input  wire logic                              z_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  z_target,
    input  wire logic                              e_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  e_target,
    input  wire logic                              f_valid,
    input  wire logic [lms_pkg::FEED_W-1:0]        feed_rate,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output lms_pkg::cmd_t                          q_cmd
);

    logic signed [lms_pkg::POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [lms_pkg::POS_W-1:0] pos_y_reg, pos_y_next;
    logic signed [lms_pkg::POS_W-1:0] pos_z_reg, pos_z_next;
    logic signed [lms_pkg::POS_W-1:0] ext_reg, ext_next;
    logic [lms_pkg::FEED_W-1:0]       feed_reg, feed_next;
    logic                             abs_reg, abs_next;

    logic                               accept;
    logic [lms_pkg::FEED_W-1:0]         hf;
    logic signed [lms_pkg::POS_W-1:0]   ox, oy, oz, oe;
    logic signed [lms_pkg::DELTA_W-1:0] dx, dy, dz, de;
    logic                               no_xyz;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Offsets and dead-banded deltas of the incoming command
    always_comb begin
        hf = f_valid ? feed_rate : feed_reg;
        ox = x_valid ? x_target : '0;
        oy = y_valid ? y_target : '0;
        oz = z_valid ? z_target : '0;
        oe = e_valid ? e_target : '0;
        dx = lms_pkg::dead_band(x_valid ?
             (lms_pkg::DELTA_W'(x_target) - lms_pkg::DELTA_W'(pos_x_reg)) : '0);
        dy = lms_pkg::dead_band(y_valid ?
             (lms_pkg::DELTA_W'(y_target) - lms_pkg::DELTA_W'(pos_y_reg)) : '0);
        dz = lms_pkg::dead_band(z_valid ?
             (lms_pkg::DELTA_W'(z_target) - lms_pkg::DELTA_W'(pos_z_reg)) : '0);
        de = lms_pkg::dead_band(e_valid ?
             (lms_pkg::DELTA_W'(e_target) - lms_pkg::DELTA_W'(ext_reg)) : '0);
        no_xyz = (dx == '0) && (dy == '0) && (dz == '0);
    end

    // Classification and next state
    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        ext_next   = ext_reg;
        feed_next  = feed_reg;
        abs_next   = abs_reg;
        q_push     = 1'b0;

        q_cmd        = '0;
        q_cmd.x      = pos_x_reg;
        q_cmd.y      = pos_y_reg;
        q_cmd.z      = pos_z_reg;
        q_cmd.e      = ext_reg;
        q_cmd.spd_x  = hf;
        q_cmd.spd_y  = hf;
        q_cmd.spd_z  = hf;

        if (accept) begin
            case (lms_pkg::req_t'(req_type))
                lms_pkg::REQ_ABS: begin
                    abs_next = 1'b1;
                end
                lms_pkg::REQ_REL: begin
                    abs_next = 1'b0;
                end
                lms_pkg::REQ_HOME: begin
                    if (x_valid) pos_x_next = '0;
                    if (y_valid) pos_y_next = '0;
                    if (z_valid) pos_z_next = '0;
                end
                lms_pkg::REQ_SETPOS: begin
                    if (e_valid) ext_next = '0;
                end
                lms_pkg::REQ_MOVE: begin
                    feed_next = hf;
                    q_push    = 1'b1;
                    if (!abs_reg) begin
                        q_cmd.is_rel = 1'b1;
                        q_cmd.x      = ox;
                        q_cmd.y      = oy;
                        q_cmd.z      = oz;
                        q_cmd.e      = oe;
                        pos_x_next   = pos_x_reg + ox;
                        pos_y_next   = pos_y_reg + oy;
                        pos_z_next   = pos_z_reg + oz;
                        ext_next     = ext_reg + oe;
                    end else if (no_xyz) begin
                        q_cmd.e  = ext_reg + de[lms_pkg::POS_W-1:0];
                        ext_next = ext_reg + de[lms_pkg::POS_W-1:0];
                    end else if (dz != '0) begin
                        q_cmd.z    = z_target;
                        pos_z_next = z_target;
                    end else begin
                        q_cmd.is_xy = 1'b1;
                        q_cmd.dx    = dx;
                        q_cmd.dy    = dy;
                        q_cmd.de    = de;
                        q_cmd.spd_x = (hf < cfg.ssx) ? hf : cfg.ssx;
                        q_cmd.spd_y = (hf < cfg.ssy) ? hf : cfg.ssy;
                        pos_x_next  = pos_x_reg + dx[lms_pkg::POS_W-1:0];
                        pos_y_next  = pos_y_reg + dy[lms_pkg::POS_W-1:0];
                        ext_next    = ext_reg + de[lms_pkg::POS_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            ext_reg   <= '0;
            feed_reg  <= '0;
            abs_reg   <= 1'b1;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            ext_reg   <= ext_next;
            feed_reg  <= feed_next;
            abs_reg   <= abs_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lms_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear move segmenter command queue
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module lms_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire lms_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output lms_pkg::cmd_t      head_cmd
);

    lms_pkg::cmd_t mem_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem_reg[rptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear move segmenter back end
// Works out the segment count of an XY move by reciprocal multiplication and
// the per-segment steps with a serial divider, then issues the segments
// through an output register; any other command goes straight to that register as one final segment.
// ----------------------------------------------------------------------------
module lms_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire lms_pkg::cfg_t cfg,
    input  wire logic          head_valid,
    input  wire lms_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lms_pkg::seg_t      out_seg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NCALC,
        ST_NDIV,
        ST_NSET,
        ST_DDIV,
        ST_EMIT
    } state_t;

    localparam int SC  = lms_pkg::SEG_CNT_W;
    localparam int PW  = lms_pkg::POS_W;
    localparam int NPW = lms_pkg::NREM_W + lms_pkg::RECIP_W;

    state_t                            state_reg;
    lms_pkg::cmd_t                     cmd_reg;
    logic [SC-1:0]                     n_reg;
    logic                              sat_reg;
    logic [lms_pkg::NREM_W-1:0]        nrem_reg;
    logic [lms_pkg::QUO_W-1:0]         nq_reg;
    logic [lms_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [SC-1:0]                     i_reg;
    logic [PW-1:0]                     dvd_reg  [3];
    logic [SC-1:0]                     drem_reg [3];
    logic [PW-1:0]                     mag_reg  [3];
    logic [SC-1:0]                     racc_reg [3];
    logic                              out_valid_reg;
    lms_pkg::seg_t                     out_reg;

    logic                              out_free;
    logic                              out_load;
    logic signed [lms_pkg::DELTA_W-1:0] dlt   [3];
    logic signed [PW-1:0]              start [3];
    logic [PW-1:0]                     dmag  [3];
    logic [SC:0]                       dtrial [3];
    logic                              dge   [3];
    logic [SC:0]                       rsum  [3];
    logic                              rc    [3];
    logic [SC-1:0]                     racc_n [3];
    logic [PW-1:0]                     mag_n [3];
    logic signed [PW-1:0]              seg_v [3];
    logic [lms_pkg::SUM_W-1:0]         xy_sum;
    logic [lms_pkg::PROD_W-1:0]        prod;
    logic [NPW-1:0]                    nprod;
    logic [SC-1:0]                     i_n;
    logic                              is_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_seg   = out_reg;
    assign pop       = (state_reg == ST_IDLE) && head_valid && (head_cmd.is_xy || out_free);
    assign out_load  = (pop && !head_cmd.is_xy) || ((state_reg == ST_EMIT) && out_free);

    // Per-lane datapath: X, Y and extruder
    always_comb begin
        dlt[0]   = cmd_reg.dx;
        dlt[1]   = cmd_reg.dy;
        dlt[2]   = cmd_reg.de;
        start[0] = cmd_reg.x;
        start[1] = cmd_reg.y;
        start[2] = cmd_reg.e;
        for (int k = 0; k < 3; k++) begin
            dmag[k]   = dlt[k][lms_pkg::DELTA_W-1] ? PW'(-dlt[k]) : PW'(dlt[k]);
            dtrial[k] = {drem_reg[k], dvd_reg[k][PW-1]};
            dge[k]    = (dtrial[k] >= {1'b0, n_reg});
            rsum[k]   = {1'b0, racc_reg[k]} + {1'b0, drem_reg[k]};
            rc[k]     = (rsum[k] >= {1'b0, n_reg});
            racc_n[k] = rc[k] ? SC'(rsum[k] - {1'b0, n_reg}) : SC'(rsum[k]);
            mag_n[k]  = mag_reg[k] + dvd_reg[k] + PW'(rc[k]);
            seg_v[k]  = dlt[k][lms_pkg::DELTA_W-1] ? (start[k] - mag_n[k])
                                                    : (start[k] + mag_n[k]);
        end
        xy_sum  = lms_pkg::SUM_W'(dmag[0]) + lms_pkg::SUM_W'(dmag[1]);
        prod    = lms_pkg::PROD_W'(xy_sum) * lms_pkg::PROD_W'(cfg.spm);
        nprod   = NPW'(nrem_reg) * NPW'(lms_pkg::RECIP_MUL);
        i_n     = i_reg + SC'(1);
        is_last = (i_n == n_reg);
    end

    // Sequencer, dividers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        cmd_reg <= head_cmd;
                        if (head_cmd.is_xy) begin
                            state_reg <= ST_NCALC;
                        end else begin
                            out_reg <= '{x: head_cmd.x, y: head_cmd.y,
                                         z: head_cmd.z, e: head_cmd.e,
                                         spd_x: head_cmd.spd_x,
                                         spd_y: head_cmd.spd_y,
                                         spd_z: head_cmd.spd_z,
                                         is_rel: head_cmd.is_rel, last: 1'b1};
                        end
                    end
                end
                ST_NCALC: begin
                    // Travel times resolution; saturation is decided on the full product
                    sat_reg  <= (prod >= lms_pkg::PROD_W'(lms_pkg::SAT_LIMIT));
                    nrem_reg <= prod[lms_pkg::NREM_W-1:0];
                    for (int k = 0; k < 3; k++) begin
                        dvd_reg[k]  <= dmag[k];
                        drem_reg[k] <= '0;
                    end
                    state_reg <= ST_NDIV;
                end
                ST_NDIV: begin
                    // Floor division by a millimetre through the reciprocal
                    nq_reg    <= nprod[lms_pkg::RECIP_SHIFT +: lms_pkg::QUO_W];
                    state_reg <= ST_NSET;
                end
                ST_NSET: begin
                    if (sat_reg) begin
                        n_reg <= SC'(lms_pkg::MAX_SEGMENTS);
                    end else if (nq_reg == '0) begin
                        n_reg <= SC'(1);
                    end else begin
                        n_reg <= SC'(nq_reg);
                    end
                    cnt_reg   <= lms_pkg::DIV_CNT_W'(PW - 1);
                    state_reg <= ST_DDIV;
                end
                ST_DDIV: begin
                    // One quotient bit per lane each cycle
                    for (int k = 0; k < 3; k++) begin
                        dvd_reg[k]  <= {dvd_reg[k][PW-2:0], dge[k]};
                        drem_reg[k] <= dge[k] ? SC'(dtrial[k] - {1'b0, n_reg})
                                              : SC'(dtrial[k]);
                        mag_reg[k]  <= '0;
                        racc_reg[k] <= '0;
                    end
                    i_reg <= '0;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        cnt_reg <= cnt_reg - lms_pkg::DIV_CNT_W'(1);
                    end
                end
                ST_EMIT: begin
                    // Step each lane by quotient plus remainder carry
                    if (out_free) begin
                        for (int k = 0; k < 3; k++) begin
                            mag_reg[k]  <= mag_n[k];
                            racc_reg[k] <= racc_n[k];
                        end
                        i_reg   <= i_n;
                        out_reg <= '{x: seg_v[0], y: seg_v[1], z: cmd_reg.z,
                                     e: seg_v[2], spd_x: cmd_reg.spd_x,
                                     spd_y: cmd_reg.spd_y, spd_z: cmd_reg.spd_z,
                                     is_rel: 1'b0, last: is_last};
                        if (is_last) state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/linear_move_segmenter.sv
`default_nettype none
// Path: a single-segment command goes through the command queue and is popped into
// the output register once it is free; an XY move is popped, sized by reciprocal
// multiplication (NCALC, NDIV, NSET), divided by the serial step divider (DDIV), then
// EMIT offers its segments. Throughput: one single-segment command or one XY segment
// per cycle while m_ready is high; an XY move of up to 64 segments holds the back end.
// Reset is synchronous and active low; position, feedrate and mode return to reset values.
// ----------------------------------------------------------------------------
// Linear move segmenter
// Top level: configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
module linear_move_segmenter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [3:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [2:0]                        s_req_type,
    input  wire logic                              s_x_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  s_x_target,
    input  wire logic                              s_y_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  s_y_target,
    input  wire logic                              s_z_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  s_z_target,
    input  wire logic                              s_e_valid,
    input  wire logic signed [lms_pkg::POS_W-1:0]  s_e_target,
    input  wire logic                              s_f_valid,
    input  wire logic [lms_pkg::FEED_W-1:0]        s_feed_rate,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [lms_pkg::POS_W-1:0]       m_seg_x,
    output logic signed [lms_pkg::POS_W-1:0]       m_seg_y,
    output logic signed [lms_pkg::POS_W-1:0]       m_seg_z,
    output logic signed [lms_pkg::POS_W-1:0]       m_seg_e,
    output logic [lms_pkg::FEED_W-1:0]             m_speed_x,
    output logic [lms_pkg::FEED_W-1:0]             m_speed_y,
    output logic [lms_pkg::FEED_W-1:0]             m_speed_z,
    output logic                                   m_is_relative,
    output logic                                   m_last_segment
);

    lms_pkg::cfg_t cfg_reg;
    logic          cfg_wr;
    logic          q_full, q_push, q_pop, q_valid;
    lms_pkg::cmd_t q_in, q_head;
    lms_pkg::seg_t seg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spm <= lms_pkg::SPM_RESET;
            cfg_reg.ssx <= lms_pkg::SPEED_RESET;
            cfg_reg.ssy <= lms_pkg::SPEED_RESET;
        end else if (cfg_wr) begin
            case (lms_pkg::cfg_idx_t'(paddr[3:2]))
                lms_pkg::CFG_SPM: cfg_reg.spm <= pwdata[lms_pkg::SPM_W-1:0];
                lms_pkg::CFG_SSX: cfg_reg.ssx <= pwdata[lms_pkg::FEED_W-1:0];
                lms_pkg::CFG_SSY: cfg_reg.ssy <= pwdata[lms_pkg::FEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (lms_pkg::cfg_idx_t'(paddr[3:2]))
            lms_pkg::CFG_SPM: prdata = 32'(cfg_reg.spm);
            lms_pkg::CFG_SSX: prdata = 32'(cfg_reg.ssx);
            lms_pkg::CFG_SSY: prdata = 32'(cfg_reg.ssy);
            default:          prdata = '0;
        endcase
    end

    lms_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .req_type  (s_req_type),
        .x_valid   (s_x_valid),
        .x_target  (s_x_target),
        .y_valid   (s_y_valid),
        .y_target  (s_y_target),
        .z_valid   (s_z_valid),
        .z_target  (s_z_target),
        .e_valid   (s_e_valid),
        .e_target  (s_e_target),
        .f_valid   (s_f_valid),
        .feed_rate (s_feed_rate),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in)
    );

    lms_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    lms_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (q_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_seg    (seg)
    );

    assign m_seg_x        = seg.x;
    assign m_seg_y        = seg.y;
    assign m_seg_z        = seg.z;
    assign m_seg_e        = seg.e;
    assign m_speed_x      = seg.spd_x;
    assign m_speed_y      = seg.spd_y;
    assign m_speed_z      = seg.spd_z;
    assign m_is_relative  = seg.is_rel;
    assign m_last_segment = seg.last;

    // A relative transfer is always a single, final segment.
    a_rel_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_relative |-> m_last_segment)
        else $error("relative segment without last flag");

    // Relative segments carry the held feedrate on every axis.
    a_rel_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_relative |-> (m_speed_x == m_speed_z) && (m_speed_y == m_speed_z))
        else $error("relative segment speeds differ");

    // XY speeds never exceed the feedrate carried in speed_z.
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_speed_x <= m_speed_z) && (m_speed_y <= m_speed_z))
        else $error("segment speed above feedrate");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule
`default_nettype wire

FILE: tb/linear_move_segmenter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear move segmenter testbench
// Drives motion commands through the valid/ready input channel, predicts every
// result segment from its own copy of the planner state and checks each
// transfer on the result channel field by field, with random sender gaps,
// receiver stalls and register changes between phases.
// ----------------------------------------------------------------------------
module linear_move_segmenter_test;

    typedef struct packed {
        logic [2:0]         req;
        logic               xv;
        logic signed [23:0] xt;
        logic               yv;
        logic signed [23:0] yt;
        logic               zv;
        logic signed [23:0] zt;
        logic               ev;
        logic signed [23:0] et;
        logic               fv;
        logic [15:0]        feed;
    } command_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 600;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    command_t drv = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lms_pkg::seg_t got;

    linear_move_segmenter dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(drv.req), .s_x_valid(drv.xv), .s_x_target(drv.xt),
        .s_y_valid(drv.yv), .s_y_target(drv.yt), .s_z_valid(drv.zv),
        .s_z_target(drv.zt), .s_e_valid(drv.ev), .s_e_target(drv.et),
        .s_f_valid(drv.fv), .s_feed_rate(drv.feed),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_seg_x(got.x), .m_seg_y(got.y), .m_seg_z(got.z), .m_seg_e(got.e),
        .m_speed_x(got.spd_x), .m_speed_y(got.spd_y), .m_speed_z(got.spd_z),
        .m_is_relative(got.is_rel), .m_last_segment(got.last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted planner state and registers
    logic [6:0]         plan_spm;
    logic [15:0]        plan_ssx, plan_ssy;
    logic signed [23:0] plan_x, plan_y, plan_z, plan_e;
    logic [15:0]        plan_feed;
    logic               plan_abs;

    command_t      pending_cmds[$];
    lms_pkg::seg_t expected_segs[$];
    int unsigned mismatches = 0;
    int unsigned cmds_sent = 0;
    int unsigned segs_seen = 0;
    int unsigned multi_moves = 0;
    int unsigned idle_cycles = 0;
    bit sender_paused = 1'b0;
    bit long_stall = 1'b0;
    bit hold_done = 1'b0;
    bit timed_out = 1'b0;

    function automatic longint trim(input longint d);
        return (d > -lms_pkg::DEAD_BAND && d < lms_pkg::DEAD_BAND) ? 0 : d;
    endfunction

    function automatic longint absval(input longint d);
        return d < 0 ? -d : d;
    endfunction

    // Append a predicted segment to the scoreboard.
    function automatic void add_expected(input lms_pkg::seg_t s);
        expected_segs = {expected_segs, s};
    endfunction

    // Append a command to the driver's pending list.
    function automatic void queue_cmd(input command_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic lms_pkg::seg_t make_seg(input longint x, input longint y,
                                               input longint z, input longint e,
                                               input logic [15:0] sx, input logic [15:0] sy,
                                               input logic [15:0] sz,
                                               input logic rel, input logic last);
        lms_pkg::seg_t s;
        s.x = 24'(x); s.y = 24'(y); s.z = 24'(z); s.e = 24'(e);
        s.spd_x = sx; s.spd_y = sy; s.spd_z = sz;
        s.is_rel = rel; s.last = last;
        return s;
    endfunction

    // Work out the segments one accepted command causes and advance the state.
    task automatic plan_command(input command_t c);
        longint dx, dy, dz, de, n, ex, ey, ee, ox, oy, oz, oe;
        logic [15:0] sx, sy;
        case (c.req)
            lms_pkg::REQ_ABS: plan_abs = 1'b1;
            lms_pkg::REQ_REL: plan_abs = 1'b0;
            lms_pkg::REQ_HOME: begin
                if (c.xv) plan_x = '0;
                if (c.yv) plan_y = '0;
                if (c.zv) plan_z = '0;
            end
            lms_pkg::REQ_SETPOS: if (c.ev) plan_e = '0;
            lms_pkg::REQ_MOVE: begin
                if (c.fv) plan_feed = c.feed;
                if (!plan_abs) begin
                    ox = c.xv ? c.xt : 0; oy = c.yv ? c.yt : 0;
                    oz = c.zv ? c.zt : 0; oe = c.ev ? c.et : 0;
                    add_expected(make_seg(ox, oy, oz, oe, plan_feed, plan_feed,
                                          plan_feed, 1'b1, 1'b1));
                    plan_x += 24'(ox); plan_y += 24'(oy);
                    plan_z += 24'(oz); plan_e += 24'(oe);
                end else begin
                    dx = trim(c.xv ? longint'(c.xt) - plan_x : 0);
                    dy = trim(c.yv ? longint'(c.yt) - plan_y : 0);
                    dz = trim(c.zv ? longint'(c.zt) - plan_z : 0);
                    de = trim(c.ev ? longint'(c.et) - plan_e : 0);
                    if (dx == 0 && dy == 0 && dz == 0) begin
                        ee = plan_e + de;
                        add_expected(make_seg(plan_x, plan_y, plan_z, ee, plan_feed,
                                              plan_feed, plan_feed, 1'b0, 1'b1));
                        plan_e = 24'(ee);
                    end else if (dz != 0) begin
                        add_expected(make_seg(plan_x, plan_y, c.zt, plan_e, plan_feed,
                                              plan_feed, plan_feed, 1'b0, 1'b1));
                        plan_z = c.zt;
                    end else begin
                        n = ((absval(dx) + absval(dy)) * plan_spm) / 1000;
                        if (n < 1) n = 1;
                        if (n > lms_pkg::MAX_SEGMENTS) n = lms_pkg::MAX_SEGMENTS;
                        if (n > 1) multi_moves++;
                        sx = plan_feed < plan_ssx ? plan_feed : plan_ssx;
                        sy = plan_feed < plan_ssy ? plan_feed : plan_ssy;
                        ex = plan_x; ey = plan_y; ee = plan_e;
                        for (longint i = 1; i <= n; i++) begin
                            ex = plan_x + (dx * i) / n;
                            ey = plan_y + (dy * i) / n;
                            ee = plan_e + (de * i) / n;
                            add_expected(make_seg(ex, ey, plan_z, ee, sx, sy,
                                                  plan_feed, 1'b0, i == n));
                        end
                        plan_x = 24'(ex); plan_y = 24'(ey); plan_e = 24'(ee);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Driver: bursts of transfers with random gaps; pauses when asked.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                plan_command(drv);
                cmds_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !sender_paused) begin
                    drv <= pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off counted here on request.
    int stall_phase = 0;
    int hold_count = 0;
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (long_stall && !hold_done) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == LONG_HOLD - 1) hold_done <= 1'b1;
        end
        else if (stall_phase[8]) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        lms_pkg::seg_t want;
        if (aresetn && m_valid && m_ready) begin
            segs_seen++;
            if (expected_segs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected segment %p", got);
            end else begin
                want = expected_segs.pop_front();
                if (want !== got) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("segment mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d segments outstanding", expected_segs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(input lms_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            lms_pkg::CFG_SPM: plan_spm = val[6:0];
            lms_pkg::CFG_SSX: plan_ssx = val[15:0];
            default: plan_ssy = val[15:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_valid || expected_segs.size() > 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function automatic command_t cmd(input lms_pkg::req_t r, input logic [4:0] v,
                                     input int x, input int y, input int z, input int e,
                                     input int f);
        command_t c;
        c.req = r;
        {c.xv, c.yv, c.zv, c.ev, c.fv} = v;
        c.xt = 24'(x); c.yt = 24'(y); c.zt = 24'(z); c.et = 24'(e); c.feed = 16'(f);
        return c;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 199) - 100;
            1: return $signed(24'($urandom));
            default: return $urandom_range(0, 12000) - 6000;
        endcase
    endfunction

    function automatic command_t rand_cmd();
        command_t c;
        int k;
        k = $urandom_range(0, 19);
        c.req = (k < 14) ? lms_pkg::REQ_MOVE : (k == 14) ? lms_pkg::REQ_ABS :
                (k == 15) ? lms_pkg::REQ_REL : (k == 16) ? lms_pkg::REQ_HOME :
                (k == 17) ? lms_pkg::REQ_SETPOS : 3'($urandom_range(5, 7));
        {c.xv, c.yv, c.zv, c.ev, c.fv} = 5'($urandom);
        if ($urandom_range(0, 2) != 0) c.zv = 1'b0;
        c.xt = 24'(rand_coord()); c.yt = 24'(rand_coord());
        c.zt = 24'(rand_coord()); c.et = 24'(rand_coord());
        c.feed = 16'($urandom);
        return c;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) queue_cmd(rand_cmd());
        wait_drained();
    endtask

    initial begin
        plan_spm = lms_pkg::SPM_RESET;
        plan_ssx = lms_pkg::SPEED_RESET; plan_ssy = lms_pkg::SPEED_RESET;
        plan_x = '0; plan_y = '0; plan_z = '0; plan_e = '0;
        plan_feed = '0; plan_abs = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: dead band, Z-only, extruder-only, XY split, mode sets, home.
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b11001, 50, -99, 0, 0, 65535));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b00010, 0, 0, 0, 500, 0));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b00100, 0, 0, 2000, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b11011, 3000, -2500, 0, 900, 1500));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b10000, 3100, 0, 0, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b11000, 8388607, -8388608, 0, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b11111, -8388608, 8388607, -8388608,
                      8388607, 0));
        queue_cmd(cmd(lms_pkg::REQ_HOME, 5'b11100, 0, 0, 0, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_SETPOS, 5'b00010, 0, 0, 0, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_REL, 5'b00000, 0, 0, 0, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b11111, 8388607, -8388608, 120, -5, 7));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b00000, 0, 0, 0, 0, 0));
        queue_cmd(command_t'({3'd7, 117'h0}));
        queue_cmd(cmd(lms_pkg::REQ_ABS, 5'b00000, 0, 0, 0, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_HOME, 5'b11100, 0, 0, 0, 0, 0));
        queue_cmd(cmd(lms_pkg::REQ_MOVE, 5'b11000, 100, 0, 0, 0, 0));
        wait_drained();

        // Register extremes, each followed by a random phase.
        reg_write(lms_pkg::CFG_SPM, 64); reg_write(lms_pkg::CFG_SSX, 0);
        reg_write(lms_pkg::CFG_SSY, 65535);
        random_phase(60);
        reg_write(lms_pkg::CFG_SPM, 0); reg_write(lms_pkg::CFG_SSX, 65535);
        reg_write(lms_pkg::CFG_SSY, 0);
        random_phase(40);
        reg_write(lms_pkg::CFG_SPM, 1); reg_write(lms_pkg::CFG_SSX, 300);
        reg_write(lms_pkg::CFG_SSY, 800);
        random_phase(60);

        // Long receiver hold-off while the sender keeps offering commands.
        reg_write(lms_pkg::CFG_SPM, 20);
        for (int i = 0; i < 40; i++) queue_cmd(rand_cmd());
        long_stall = 1'b1;
        while (!hold_done) @(posedge aclk);
        long_stall = 1'b0;
        wait_drained();

        // Sender pause mid-stream until every result has arrived.
        for (int i = 0; i < 20; i++) queue_cmd(rand_cmd());
        repeat (30) @(posedge aclk);
        sender_paused = 1'b1;
        while (s_valid || expected_segs.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        sender_paused = 1'b0;
        wait_drained();

        // Final phase with random register values.
        reg_write(lms_pkg::CFG_SPM, $urandom_range(2, 63));
        reg_write(lms_pkg::CFG_SSX, $urandom_range(0, 65535));
        reg_write(lms_pkg::CFG_SSY, $urandom_range(0, 65535));
        random_phase(60);

        $display("ran %0d commands, checked %0d segments, %0d multi-segment moves",
                 cmds_sent, segs_seen, multi_moves);
        if (mismatches == 0 && expected_segs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d segments missing", mismatches,
                     expected_segs.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
